>>> hdl/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg: shared types and constants for the packet framer
// Byte selector codes, CRC constants, the CRC control bundle and the
// byte-wide CRC update.
// ----------------------------------------------------------------------------
package pfc_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned CRC_W     = 16;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CRC_W-1:0]  CRC_SEED = 16'hFFFF;
	localparam logic [CRC_W-1:0]  CRC_POLY = 16'h1021;

	localparam logic [BYTE_W-1:0] MARKER_RST = 8'd254;
	localparam logic [BYTE_W-1:0] SYS_ID_RST = 8'd1;
	localparam logic [BYTE_W-1:0] CMP_ID_RST = 8'd1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYSTEM_ID    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COMPONENT_ID = 2'd2;

	// which byte of the frame goes out next
	typedef enum logic [3:0] {
		SEL_MARK,
		SEL_LEN,
		SEL_SEQ,
		SEL_SYS,
		SEL_COMP,
		SEL_MSG,
		SEL_DATA,
		SEL_CRCLO,
		SEL_CRCHI
	} byte_sel_t;

	typedef struct packed {
		logic              clear;
		logic              feed;
		logic [BYTE_W-1:0] data;
	} crc_ctl_t;

	// MSB-first CRC, one byte per call
	function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> hdl/pfc_crc.sv
// ----------------------------------------------------------------------------
// pfc_crc: running CRC-16 of the frame
// Clear to the seed or, while feed is set, fold in one byte per cycle.
// ----------------------------------------------------------------------------
module pfc_crc (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pfc_pkg::crc_ctl_t        ctl,
	output logic [pfc_pkg::CRC_W-1:0] crc
);
	import pfc_pkg::*;

	logic [CRC_W-1:0] crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_SEED;
		end else if (ctl.clear) begin
			crc_q <= CRC_SEED;
		end else if (ctl.feed) begin
			crc_q <= crc_feed(crc_q, ctl.data);
		end
	end

	assign crc = crc_q;

	// clear wins over feed
	a_clear_seed: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear |=> crc_q == CRC_SEED)
		else $error("crc not at seed after clear");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!ctl.clear && !ctl.feed) |=> $stable(crc_q))
		else $error("crc changed without feed");

	a_feed: assert property (@(posedge clk) disable iff (!arst_n)
		(!ctl.clear && ctl.feed) |=> crc_q == crc_feed($past(crc_q), $past(ctl.data)))
		else $error("crc feed mismatch");

endmodule

>>> hdl/packet_framer_crc16.sv
// ----------------------------------------------------------------------------
// packet_framer_crc16: streaming frame encoder with CRC-16 trailer
// Wraps payload bytes in a six-byte header and a two-byte CRC trailer.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake           Word
// -------   ---------  ------------------  ------------------------------------
// in        sink       in_valid/in_stall   message_id, payload_length, data_byte
// out       source     out_valid/out_stall out_byte, frame_start, frame_end
// cfg       sink       cfg_wr_en           cfg_index, cfg_wdata
//
// One output byte leaves the output register per cycle while out_stall is
// low; that register and its single-byte mux set the rate. A mid-frame word
// gives 1 byte, a frame's first word 7 bytes (header plus data), an empty
// frame 8, and a closing word adds 2 for the CRC. Input reaches the output
// through the held word and then the output register. Reset (arst_n low)
// returns to idle: sequence 0, CRC seed, registers at defaults. in_stall
// rises while the held word still has bytes to emit or out_stall holds the output register full.
// ----------------------------------------------------------------------------
module packet_framer_crc16 (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_wr_en,
	input  logic [pfc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pfc_pkg::BYTE_W-1:0]        cfg_wdata,
	// input words
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [pfc_pkg::BYTE_W-1:0]        message_id,
	input  logic [pfc_pkg::BYTE_W-1:0]        payload_length,
	input  logic [pfc_pkg::BYTE_W-1:0]        data_byte,
	// output words
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [pfc_pkg::BYTE_W-1:0]        out_byte,
	output logic                              frame_start,
	output logic                              frame_end
);
	import pfc_pkg::*;

	// configuration registers
	logic [BYTE_W-1:0] marker_q, sys_id_q, cmp_id_q;

	// framing state
	logic [BYTE_W-1:0] seq_q;   // sequence number for the next header
	logic [BYTE_W-1:0] bif_q;   // payload bytes sent so far, 0 between frames

	// held input word and its plan
	logic              busy_q;
	byte_sel_t         sel_q, sel_nxt;
	logic [BYTE_W-1:0] msg_s1, len_s1, data_s1, seq_s1;
	logic              hdr_s1, fin_s1;

	// output register
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              start_q, end_q;

	// control
	logic              adv, last, accept;
	logic              hdr_in, fin_in;
	logic [BYTE_W-1:0] byte_nxt;
	logic              covered;
	logic [CRC_W-1:0]  crc;
	crc_ctl_t          crc_ctl;

	// --- configuration writes; out-of-range index is dropped ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= MARKER_RST;
			sys_id_q <= SYS_ID_RST;
			cmp_id_q <= CMP_ID_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_START_MARKER: marker_q <= cfg_wdata;
				CFG_SYSTEM_ID:    sys_id_q <= cfg_wdata;
				CFG_COMPONENT_ID: cmp_id_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// --- handshake ---
	// Advance when a byte is pending and the output register is free or draining.
	assign adv      = busy_q && (!out_valid_q || !out_stall);
	assign last     = (sel_q == SEL_CRCHI) || (sel_q == SEL_DATA && !fin_s1);
	assign in_stall = busy_q && !(adv && last);
	assign accept   = in_valid && !in_stall;

	// Decide at accept time whether this word opens and/or closes a frame.
	// A mid-frame word closes once the count, itself included, reaches the
	// word's length; a length change mid-frame can close it early.
	assign hdr_in = (bif_q == '0);
	always_comb begin
		if (hdr_in) begin
			fin_in = (payload_length <= 8'd1);
		end else begin
			fin_in = ({1'b0, bif_q} + 9'd1) >= {1'b0, payload_length};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '0;
			bif_q <= '0;
		end else if (accept) begin
			if (hdr_in) begin
				seq_q <= seq_q + 8'd1;
			end
			if (fin_in) begin
				bif_q <= '0;
			end else begin
				bif_q <= hdr_in ? 8'd1 : bif_q + 8'd1;
			end
		end
	end

	// --- held word ---
	always_ff @(posedge clk) begin
		if (accept) begin
			msg_s1  <= message_id;
			len_s1  <= payload_length;
			data_s1 <= data_byte;
			seq_s1  <= seq_q;
			hdr_s1  <= hdr_in;
			fin_s1  <= fin_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sel_q  <= SEL_MARK;
		end else if (accept) begin
			busy_q <= 1'b1;
			sel_q  <= hdr_in ? SEL_MARK : SEL_DATA;
		end else if (adv) begin
			busy_q <= !last;
			sel_q  <= sel_nxt;
		end
	end

	// --- byte sequencer: pick the byte to load and the step after it ---
	always_comb begin
		byte_nxt = data_s1;
		sel_nxt  = sel_q;
		covered  = 1'b0;
		unique case (sel_q)
			SEL_MARK: begin
				byte_nxt = marker_q;
				sel_nxt  = SEL_LEN;
			end
			SEL_LEN: begin
				byte_nxt = len_s1;
				covered  = 1'b1;
				sel_nxt  = SEL_SEQ;
			end
			SEL_SEQ: begin
				byte_nxt = seq_s1;
				covered  = 1'b1;
				sel_nxt  = SEL_SYS;
			end
			SEL_SYS: begin
				byte_nxt = sys_id_q;
				covered  = 1'b1;
				sel_nxt  = SEL_COMP;
			end
			SEL_COMP: begin
				byte_nxt = cmp_id_q;
				covered  = 1'b1;
				sel_nxt  = SEL_MSG;
			end
			SEL_MSG: begin
				byte_nxt = msg_s1;
				covered  = 1'b1;
				// an empty frame skips the data byte
				sel_nxt  = (len_s1 == '0) ? SEL_CRCLO : SEL_DATA;
			end
			SEL_DATA: begin
				byte_nxt = data_s1;
				covered  = 1'b1;
				sel_nxt  = fin_s1 ? SEL_CRCLO : SEL_DATA;
			end
			SEL_CRCLO: begin
				byte_nxt = crc[7:0];
				sel_nxt  = SEL_CRCHI;
			end
			SEL_CRCHI: begin
				byte_nxt = crc[15:8];
				sel_nxt  = SEL_CRCHI;
			end
			default: begin
				byte_nxt = data_s1;
				sel_nxt  = SEL_MARK;
			end
		endcase
	end

	// --- CRC: reseed on the marker and after the high CRC byte ---
	assign crc_ctl.clear = adv && (sel_q == SEL_MARK || sel_q == SEL_CRCHI);
	assign crc_ctl.feed  = adv && covered;
	assign crc_ctl.data  = byte_nxt;

	pfc_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.crc    (crc)
	);

	// --- output register ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= byte_nxt;
			start_q    <= (sel_q == SEL_MARK);
			end_q      <= (sel_q == SEL_CRCHI);
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign frame_start = start_q;
	assign frame_end   = end_q;

	// --- checks ---
	a_mark_seed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && start_q) |-> crc == CRC_SEED)
		else $error("crc not seeded while marker is out");

	a_crc_only_closing: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && (sel_q == SEL_CRCLO || sel_q == SEL_CRCHI)) |-> fin_s1)
		else $error("crc trailer on a word that does not close the frame");

	a_hdr_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && hdr_in) |=> (busy_q && sel_q == SEL_MARK && hdr_s1))
		else $error("frame opener did not start at the marker");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && sel_q == SEL_CRCHI) |-> (bif_q == '0 || $past(accept)))
		else $error("frame count not cleared at frame end");

endmodule

>>> sim/tb_packet_framer_crc16.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packet_framer_crc16: self-checking bench for the CRC-16 packet framer
// Feeds payload words in bursts against a receiver that stalls on a pattern
// of its own. Every frame byte (header, payload, CRC trailer) is predicted
// in the bench and compared field by field. Covers empty frames, lengths
// grown, shrunk or zeroed mid-frame, message id noise, the longest frame and
// several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_packet_framer_crc16;
	import pfc_pkg::*;

	localparam int unsigned CLK_PERIOD       = 20;
	localparam int unsigned TIMEOUT_NS       = 10_000_000;
	localparam int unsigned DRAIN_CYCLES     = 20;
	localparam int unsigned WORDS_PER_PHASE  = 60;
	localparam int unsigned FRAMES_PER_PHASE = 15;
	localparam int unsigned HOLD_CYCLES      = 150;
	localparam int unsigned HOLD_SPACING     = 600;
	localparam int unsigned MAX_PRINTED      = 40;

	// index past the last register; writes to it must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	// one byte of the serialized frame as it leaves the block
	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic              sof;
		logic              eof;
	} frame_byte_t;

	// directed word plus what it must produce: byte count and first byte
	typedef struct packed {
		logic [BYTE_W-1:0] msg;
		logic [BYTE_W-1:0] len;
		logic [BYTE_W-1:0] data;
		logic [3:0]        count;
		logic [BYTE_W-1:0] first;
	} directed_row_t;

	// registers at reset values: marker FE, system 1, component 1, sequence 0
	localparam directed_row_t DIRECTED_ROWS [0:18] = '{
		'{8'h00, 8'd0,   8'hFF, 4'd8, 8'hFE},	// empty frame, data ignored
		'{8'hFF, 8'd1,   8'h00, 4'd9, 8'hFE},	// one-byte frame: header, data, CRC
		'{8'hA5, 8'd3,   8'hFF, 4'd7, 8'hFE},	// three-byte frame
		'{8'hA5, 8'd3,   8'h5A, 4'd1, 8'h5A},
		'{8'hA5, 8'd3,   8'h00, 4'd3, 8'h00},
		'{8'h11, 8'd4,   8'h80, 4'd7, 8'hFE},	// message id changes mid-frame
		'{8'h22, 8'd4,   8'h01, 4'd1, 8'h01},
		'{8'h33, 8'd4,   8'h7F, 4'd1, 8'h7F},
		'{8'h44, 8'd4,   8'hFE, 4'd3, 8'hFE},
		'{8'h80, 8'd255, 8'hC3, 4'd7, 8'hFE},	// longest length, then shrunk
		'{8'h80, 8'd1,   8'h3C, 4'd3, 8'h3C},
		'{8'h01, 8'd5,   8'h10, 4'd7, 8'hFE},	// zero length mid-frame
		'{8'h01, 8'd0,   8'h20, 4'd3, 8'h20},
		'{8'h02, 8'd2,   8'hAA, 4'd7, 8'hFE},	// length grown mid-frame
		'{8'h02, 8'd3,   8'hBB, 4'd1, 8'hBB},
		'{8'h02, 8'd3,   8'hCC, 4'd3, 8'hCC},
		'{8'h7E, 8'd2,   8'h55, 4'd7, 8'hFE},	// two-byte frame
		'{8'h7E, 8'd2,   8'hAA, 4'd3, 8'hAA},
		'{8'hFF, 8'd0,   8'h00, 4'd8, 8'hFE}	// empty frame again
	};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0]    cfg_wdata;
	logic                 in_valid;
	logic                 in_stall;
	logic [BYTE_W-1:0]    message_id;
	logic [BYTE_W-1:0]    payload_length;
	logic [BYTE_W-1:0]    data_byte;
	logic                 out_valid;
	logic                 out_stall;
	logic [BYTE_W-1:0]    out_byte;
	logic                 frame_start;
	logic                 frame_end;

	// framer state as the bench sees it
	logic [BYTE_W-1:0] hdr_marker;
	logic [BYTE_W-1:0] hdr_system;
	logic [BYTE_W-1:0] hdr_component;
	logic [BYTE_W-1:0] next_seq;
	logic [CRC_W-1:0]  running_crc;
	logic [BYTE_W-1:0] payload_sent;

	frame_byte_t       expected_bytes [$];
	int unsigned       bytes_this_word;
	logic [BYTE_W-1:0] word_first_byte;
	int unsigned       error_count = 0;
	int unsigned       random_words = 0;
	int unsigned       burst_left;
	bit                hold_active = 1'b0;

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	packet_framer_crc16 i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.message_id     (message_id),
		.payload_length (payload_length),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.frame_start    (frame_start),
		.frame_end      (frame_end)
	);

	task automatic report_mismatch(input string what);
		if (error_count < MAX_PRINTED) begin
			$display("MISMATCH at %0t: %s", $time, what);
		end
		error_count++;
	endtask

	function automatic logic [BYTE_W-1:0] rnd_byte();
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	// CRC-16, polynomial 0x1021, MSB first, one bit per step
	function automatic logic [CRC_W-1:0] bench_crc_byte(input logic [CRC_W-1:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		logic             fb;
		c = crc;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			fb = c[CRC_W-1] ^ b[i];
			c  = {c[CRC_W-2:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	// queue one frame byte; covered bytes advance the running CRC
	task automatic queue_byte(input logic [BYTE_W-1:0] value, input logic sof,
			input logic eof, input logic covered);
		if (covered) begin
			running_crc = bench_crc_byte(running_crc, value);
		end
		expected_bytes.push_back(frame_byte_t'{value, sof, eof});
		if (bytes_this_word == 0) begin
			word_first_byte = value;
		end
		bytes_this_word++;
	endtask

	// work out the frame bytes caused by one accepted word
	task automatic predict_word(input logic [BYTE_W-1:0] msg, input logic [BYTE_W-1:0] len,
			input logic [BYTE_W-1:0] data);
		logic closing;
		bytes_this_word = 0;
		if (payload_sent == 0) begin
			// idle: open a frame with the header; the marker stays out of the CRC
			running_crc = CRC_SEED;
			queue_byte(hdr_marker, 1'b1, 1'b0, 1'b0);
			queue_byte(len, 1'b0, 1'b0, 1'b1);
			queue_byte(next_seq, 1'b0, 1'b0, 1'b1);
			next_seq++;
			queue_byte(hdr_system, 1'b0, 1'b0, 1'b1);
			queue_byte(hdr_component, 1'b0, 1'b0, 1'b1);
			queue_byte(msg, 1'b0, 1'b0, 1'b1);
			if (len == 0) begin
				closing = 1'b1;
			end else begin
				queue_byte(data, 1'b0, 1'b0, 1'b1);
				payload_sent = 8'd1;
				closing = (len == 8'd1);
			end
		end else begin
			// mid-frame: the length of this word decides the end, shrunk or not
			queue_byte(data, 1'b0, 1'b0, 1'b1);
			closing = ({1'b0, payload_sent} + 9'd1 >= {1'b0, len});
			payload_sent++;
		end
		if (closing) begin
			// trailer goes out low byte first
			queue_byte(running_crc[7:0], 1'b0, 1'b0, 1'b0);
			queue_byte(running_crc[15:8], 1'b0, 1'b1, 1'b0);
			payload_sent = 8'd0;
			running_crc  = CRC_SEED;
		end
	endtask

	function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [BYTE_W-1:0] value);
		case (idx)
			CFG_START_MARKER: hdr_marker    = value;
			CFG_SYSTEM_ID:    hdr_system    = value;
			CFG_COMPONENT_ID: hdr_component = value;
			default: ;
		endcase
	endfunction

	// write all registers back to back, then one write to the unused index
	task automatic set_registers(input logic [BYTE_W-1:0] marker,
			input logic [BYTE_W-1:0] sys, input logic [BYTE_W-1:0] comp);
		logic [BYTE_W-1:0] junk;
		junk = rnd_byte();
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_START_MARKER;
		cfg_wdata <= marker;
		@(posedge clk);
		apply_register(CFG_START_MARKER, marker);
		cfg_index <= CFG_SYSTEM_ID;
		cfg_wdata <= sys;
		@(posedge clk);
		apply_register(CFG_SYSTEM_ID, sys);
		cfg_index <= CFG_COMPONENT_ID;
		cfg_wdata <= comp;
		@(posedge clk);
		apply_register(CFG_COMPONENT_ID, comp);
		cfg_index <= CFG_UNUSED;
		cfg_wdata <= junk;
		@(posedge clk);
		apply_register(CFG_UNUSED, junk);
		cfg_wr_en <= 1'b0;
	endtask

	// offer one word, hold it until it is taken, then predict its bytes
	task automatic send_word(input logic [BYTE_W-1:0] msg, input logic [BYTE_W-1:0] len,
			input logic [BYTE_W-1:0] data);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			// skip the gap while the receiver holds off, so the input backs up
			if (!hold_active && $urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 6);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid       <= 1'b1;
		message_id     <= msg;
		payload_length <= len;
		data_byte      <= data;
		do begin
			@(posedge clk);
		end while (in_stall);
		predict_word(msg, len, data);
	endtask

	// one random frame; most are well formed, the rest bend the length or id
	task automatic send_random_frame();
		int unsigned       kind;
		int unsigned       n;
		int unsigned       cut;
		logic [BYTE_W-1:0] msg;
		logic [BYTE_W-1:0] len;
		kind = $urandom_range(0, 99);
		msg  = rnd_byte();
		if (kind < 25) begin
			// empty frame: header and CRC only
			send_word(msg, 8'd0, rnd_byte());
			random_words++;
		end else if (kind < 65) begin
			n = $urandom_range(1, 6);
			repeat (n) send_word(msg, BYTE_W'(n), rnd_byte());
			random_words += n;
		end else if (kind < 77) begin
			// long header length, then a shrunk or zero length closes the frame
			len = BYTE_W'($urandom_range(7, 255));
			cut = $urandom_range(1, 5);
			repeat (cut) send_word(msg, len, rnd_byte());
			send_word(msg, BYTE_W'($urandom_range(0, cut + 1)), rnd_byte());
			random_words += cut + 1;
		end else if (kind < 87) begin
			// short header length, grown on the following words
			len = BYTE_W'($urandom_range(2, 5));
			n   = len + $urandom_range(1, 3);
			send_word(msg, len, rnd_byte());
			repeat (n - 1) send_word(msg, BYTE_W'(n), rnd_byte());
			random_words += n;
		end else begin
			// message id noise after the header went out
			n = $urandom_range(2, 6);
			repeat (n) send_word(rnd_byte(), BYTE_W'(n), rnd_byte());
			random_words += n;
		end
	endtask

	// drop valid and wait until every predicted byte has come out
	task automatic drain_frames();
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// receiver: check each accepted byte, stall on a pattern of its own
	initial begin : output_side
		frame_byte_t exp_byte;
		int unsigned stall_mode;
		int unsigned mode_left;
		int unsigned hold_left;
		int unsigned results_seen;
		int unsigned next_hold_mark;
		int unsigned tick;
		stall_mode     = 0;
		mode_left      = 0;
		hold_left      = 0;
		results_seen   = 0;
		next_hold_mark = 300;
		tick           = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (arst_n && out_valid === 1'b1 && !out_stall) begin
				results_seen++;
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %02h", out_byte));
				end else begin
					exp_byte = expected_bytes.pop_front();
					if (out_byte !== exp_byte.value) begin
						report_mismatch($sformatf("out_byte %02h, expected %02h",
							out_byte, exp_byte.value));
					end
					if (frame_start !== exp_byte.sof) begin
						report_mismatch($sformatf("frame_start %b, expected %b on byte %02h",
							frame_start, exp_byte.sof, exp_byte.value));
					end
					if (frame_end !== exp_byte.eof) begin
						report_mismatch($sformatf("frame_end %b, expected %b on byte %02h",
							frame_end, exp_byte.eof, exp_byte.value));
					end
				end
			end
			// now and then hold off for a long stretch so the block fills up
			if (hold_left == 0 && results_seen >= next_hold_mark) begin
				hold_left      = HOLD_CYCLES;
				next_hold_mark = results_seen + HOLD_SPACING;
				hold_active    = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left--;
				hold_active = (hold_left != 0);
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 3);
					mode_left  = $urandom_range(8, 80);
				end
				mode_left--;
				case (stall_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= (tick % 3 == 0);
				endcase
			end
		end
	end

	// input side: reset, directed table, random phases, then the verdict
	initial begin : input_side
		directed_row_t row;
		int unsigned   phase_words;
		int unsigned   phase_frames;
		logic [BYTE_W-1:0] big_msg;
		arst_n         <= 1'b0;
		cfg_wr_en      <= 1'b0;
		cfg_index      <= CFG_START_MARKER;
		cfg_wdata      <= '0;
		in_valid       <= 1'b0;
		message_id     <= '0;
		payload_length <= '0;
		data_byte      <= '0;
		hdr_marker     = MARKER_RST;
		hdr_system     = SYS_ID_RST;
		hdr_component  = CMP_ID_RST;
		next_seq       = '0;
		running_crc    = CRC_SEED;
		payload_sent   = '0;
		burst_left     = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed words under reset values; counts and first bytes typed in
		foreach (DIRECTED_ROWS[r]) begin
			row = DIRECTED_ROWS[r];
			send_word(row.msg, row.len, row.data);
			if (bytes_this_word != row.count) begin
				report_mismatch($sformatf("directed word %0d: %0d bytes, table says %0d",
					r, bytes_this_word, row.count));
			end
			if (word_first_byte != row.first) begin
				report_mismatch($sformatf("directed word %0d: first byte %02h, table says %02h",
					r, word_first_byte, row.first));
			end
		end

		// random phases, each under its own register setting
		for (int phase = 0; phase < 3; phase++) begin
			drain_frames();
			case (phase)
				0: set_registers(8'h00, 8'hFF, 8'h00);
				1: set_registers(8'hFF, 8'h00, 8'hFF);
				default: set_registers(rnd_byte(), rnd_byte(), rnd_byte());
			endcase
			if (phase == 2) begin
				// one full frame at the longest length
				big_msg = rnd_byte();
				repeat (255) send_word(big_msg, 8'd255, rnd_byte());
				random_words += 255;
			end
			phase_words  = random_words;
			phase_frames = 0;
			// a minimum of words and of frames in every phase
			while (random_words - phase_words < WORDS_PER_PHASE
					|| phase_frames < FRAMES_PER_PHASE) begin
				send_random_frame();
				phase_frames++;
			end
		end

		drain_frames();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("TB_ERROR");
		$finish;
	end

endmodule

>>> files.f
hdl/pfc_pkg.sv
hdl/pfc_crc.sv
hdl/packet_framer_crc16.sv
sim/tb_packet_framer_crc16.sv
